FILE: src/pila_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pila_pkg
// Shared widths, register indexes, fixed-point constants and the command and
// status types between the lux controller sequencer and its datapath.
// ---------------------------------------------------------------------------
package pila_pkg;

   // field and datapath widths
   localparam int LUX_W     = 16;
   localparam int GAIN_W    = 16;
   localparam int MODE_W    = 2;
   localparam int IDX_W     = 3;
   localparam int DUTY_W    = 8;
   localparam int ERR_W     = 18;  // difference of two Q10.6 values, signed
   localparam int INTEG_W   = 32;  // integral term, signed Q16.16
   localparam int KT_W      = 32;  // period * integral gain, unsigned
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 18;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 41;  // control sums before clamping

   // fixed-point alignment
   localparam int LUX_FRAC  = 6;   // Q10.6 fraction bits
   localparam int FF_SHIFT  = 24;  // whole lux to Q16.16 over a Q8.8 gain
   localparam int KI_SHIFT  = 14;  // Q.30 increment down to Q16.16
   localparam int KP_SHIFT  = 2;   // Q.14 proportional part up to Q16.16
   localparam int DUTY_LSB  = 16;  // integer part of Q16.16

   // feedforward divider
   localparam int QUOT_W    = LUX_W - LUX_FRAC + FF_SHIFT;
   localparam int REM_W     = GAIN_W + 1;
   localparam int DIV_CNT_W = $clog2(QUOT_W + 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUOT_W - 1);

   // limits
   localparam logic signed [ACC_W-1:0]   U_TOP     = ACC_W'(255 * 65536);
   localparam logic signed [ACC_W-1:0]   INTEG_MAX = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0]   INTEG_MIN = -ACC_W'(64'sh8000_0000);
   localparam logic signed [ERR_W-1:0]   DEAD_ZONE = ERR_W'(64);
   localparam logic [DUTY_W-1:0]         DUTY_MAX  = DUTY_W'(255);

   // control law codes; code 3 runs as the decoupled law
   localparam logic [MODE_W-1:0] MODE_FF  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PI  = 2'd1;

   // register indexes
   localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [IDX_W-1:0] REG_REF    = 3'd1;
   localparam logic [IDX_W-1:0] REG_FFG    = 3'd2;
   localparam logic [IDX_W-1:0] REG_KP     = 3'd3;
   localparam logic [IDX_W-1:0] REG_KI     = 3'd4;
   localparam logic [IDX_W-1:0] REG_PERIOD = 3'd5;

   // register reset values
   localparam logic [MODE_W-1:0] RST_MODE   = MODE_PI;
   localparam logic [LUX_W-1:0]  RST_REF    = 16'd0;
   localparam logic [GAIN_W-1:0] RST_FFG    = 16'd256;
   localparam logic [GAIN_W-1:0] RST_KP     = 16'd0;
   localparam logic [GAIN_W-1:0] RST_KI     = 16'd0;
   localparam logic [GAIN_W-1:0] RST_PERIOD = 16'd655;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_DIV_STEP,
      OP_MUL_KT,
      OP_MUL_KE,
      OP_MUL_P,
      OP_SUM,
      OP_TOTAL,
      OP_CLAMP,
      OP_FF
   } pila_op_type;

   typedef struct packed {
      pila_op_type op;
      logic        out_load;
   } pila_cmd_type;

   typedef struct packed {
      logic div_last;
   } pila_status_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [LUX_W-1:0]  reference_lux;
      logic [GAIN_W-1:0] ff_gain;
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] sample_period;
   } pila_cfg_type;

endpackage

FILE: src/pila_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pila_req_if
// Sample channel: measured and simulated illuminance, valid/ready handshake.
// ---------------------------------------------------------------------------
interface pila_req_if;
   logic                       valid;
   logic                       ready;
   logic [pila_pkg::LUX_W-1:0] measured_lux;
   logic [pila_pkg::LUX_W-1:0] sim_lux;

   modport source (output valid, output measured_lux, output sim_lux, input ready);
   modport sink   (input valid, input measured_lux, input sim_lux, output ready);
endinterface

FILE: src/pila_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pila_rsp_if
// Result channel: LED duty and limiter flags, valid/ready handshake.
// ---------------------------------------------------------------------------
interface pila_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pila_pkg::DUTY_W-1:0] duty;
   logic                        clamped_high;
   logic                        clamped_low;
   logic                        integral_held;

   modport source (output valid, output duty, output clamped_high,
                   output clamped_low, output integral_held, input ready);
   modport sink   (input valid, input duty, input clamped_high,
                   input clamped_low, input integral_held, output ready);
endinterface

FILE: src/pi_lux_controller_antiwindup.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pi_lux_controller_antiwindup
// PI illuminance controller with feedforward and back-calculation anti-windup.
// ---------------------------------------------------------------------------
// One sample transaction in, one duty transaction out. Feedback mode makes
// three passes through one shared multiplier, two sums and the clamp before
// it loads the result into the output register. Decoupled mode first runs
// the bit-serial feedforward divider at one quotient bit per cycle;
// feedforward-only mode runs the divider and one result step. The next
// sample is accepted in the cycle after the result loads, while that result
// waits to be taken. The integral resets to zero; the user must write
// registers through the csr port only while no transaction is in flight
// (the block itself does not enforce this), and indexes past the last
// register are ignored.
module pi_lux_controller_antiwindup (
   input  logic                              clock,
   input  logic                              reset,
   pila_req_if.sink                          req_bus,
   pila_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [pila_pkg::IDX_W-1:0]        csr_index,
   input  logic [pila_pkg::LUX_W-1:0]        csr_wdata
);

   logic [pila_pkg::MODE_W-1:0] mode_ff;
   logic [pila_pkg::LUX_W-1:0]  reference_lux_ff;
   logic [pila_pkg::GAIN_W-1:0] ff_gain_ff;
   logic [pila_pkg::GAIN_W-1:0] prop_gain_ff;
   logic [pila_pkg::GAIN_W-1:0] integ_gain_ff;
   logic [pila_pkg::GAIN_W-1:0] sample_period_ff;

   pila_pkg::pila_cfg_type      cfg;
   pila_pkg::pila_cmd_type      cmd;
   pila_pkg::pila_status_type   status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= pila_pkg::RST_MODE;
         reference_lux_ff <= pila_pkg::RST_REF;
         ff_gain_ff       <= pila_pkg::RST_FFG;
         prop_gain_ff     <= pila_pkg::RST_KP;
         integ_gain_ff    <= pila_pkg::RST_KI;
         sample_period_ff <= pila_pkg::RST_PERIOD;
      end else if (csr_we) begin
         unique case (csr_index)
            pila_pkg::REG_MODE:   mode_ff          <= csr_wdata[pila_pkg::MODE_W-1:0];
            pila_pkg::REG_REF:    reference_lux_ff <= csr_wdata;
            pila_pkg::REG_FFG:    ff_gain_ff       <= csr_wdata;
            pila_pkg::REG_KP:     prop_gain_ff     <= csr_wdata;
            pila_pkg::REG_KI:     integ_gain_ff    <= csr_wdata;
            pila_pkg::REG_PERIOD: sample_period_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode          = mode_ff;
   assign cfg.reference_lux = reference_lux_ff;
   assign cfg.ff_gain       = ff_gain_ff;
   assign cfg.prop_gain     = prop_gain_ff;
   assign cfg.integ_gain    = integ_gain_ff;
   assign cfg.sample_period = sample_period_ff;

   // sequencer
   pila_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   pila_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .req_measured_lux  (req_bus.measured_lux),
      .req_sim_lux       (req_bus.sim_lux),
      .status            (status),
      .rsp_duty          (rsp_bus.duty),
      .rsp_clamped_high  (rsp_bus.clamped_high),
      .rsp_clamped_low   (rsp_bus.clamped_low),
      .rsp_integral_held (rsp_bus.integral_held)
   );

endmodule

FILE: src/pila_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pila_datapath
// Error registers, bit-serial feedforward divider, shared multiplier,
// control sums, back-calculation clamp, integral state and result register.
// ---------------------------------------------------------------------------
module pila_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pila_pkg::pila_cfg_type        cfg,
   input  pila_pkg::pila_cmd_type        cmd,
   input  logic [pila_pkg::LUX_W-1:0]    req_measured_lux,
   input  logic [pila_pkg::LUX_W-1:0]    req_sim_lux,
   output pila_pkg::pila_status_type     status,
   output logic [pila_pkg::DUTY_W-1:0]   rsp_duty,
   output logic                          rsp_clamped_high,
   output logic                          rsp_clamped_low,
   output logic                          rsp_integral_held
);

   // error registers
   logic signed [pila_pkg::ERR_W-1:0]   e_ff, e_in;
   logic signed [pila_pkg::ERR_W-1:0]   epi_ff, epi_in;

   // divider
   logic [pila_pkg::QUOT_W-1:0]         quot_ff;
   logic [pila_pkg::REM_W-1:0]          rem_ff;
   logic [pila_pkg::DIV_CNT_W-1:0]      cnt_ff;
   logic [pila_pkg::GAIN_W-1:0]         divisor;
   logic [pila_pkg::REM_W-1:0]          rem_sh;
   logic                                div_ge;

   // multiplier and sums
   logic [pila_pkg::KT_W-1:0]           kt_ff;
   logic signed [pila_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pila_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pila_pkg::PROD_W-1:0]  mul_p;
   logic signed [pila_pkg::PROD_W-1:0]  prod_ff;
   logic signed [pila_pkg::ACC_W-1:0]   ui_ff, pf_ff, u_ff;
   logic signed [pila_pkg::ACC_W-1:0]   uff;

   // clamp
   logic signed [pila_pkg::ACC_W-1:0]   ui_new, u_sat;
   logic signed [pila_pkg::INTEG_W-1:0] integ_sat;
   logic signed [pila_pkg::INTEG_W-1:0] integral_ff;
   logic                                hi, lo, held, ff_over;

   // result and output registers
   logic [pila_pkg::DUTY_W-1:0]         res_duty_ff, rsp_duty_ff;
   logic                                res_high_ff, res_low_ff, res_held_ff;
   logic                                rsp_high_ff, rsp_low_ff, rsp_held_ff;

   // errors formed at accept
   always_comb begin
      e_in = signed'({2'b00, cfg.reference_lux}) - signed'({2'b00, req_measured_lux});
      if (cfg.mode == pila_pkg::MODE_PI) begin
         epi_in = e_in;
      end else begin
         epi_in = signed'({2'b00, req_sim_lux}) - signed'({2'b00, req_measured_lux});
      end
   end

   // restoring divider step, zero gain counts as one
   always_comb begin
      divisor = (cfg.ff_gain == '0) ? pila_pkg::GAIN_W'(1) : cfg.ff_gain;
      rem_sh  = {rem_ff[pila_pkg::REM_W-2:0], quot_ff[pila_pkg::QUOT_W-1]};
      div_ge  = rem_sh >= {1'b0, divisor};
   end

   assign status.div_last = (cnt_ff == pila_pkg::DIV_LAST);

   // feedforward term, absent in plain feedback mode
   assign uff = (cfg.mode == pila_pkg::MODE_PI) ? '0 :
                signed'(pila_pkg::ACC_W'(quot_ff));

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.op)
         pila_pkg::OP_MUL_KT: begin
            mul_a = signed'(pila_pkg::MUL_A_W'(cfg.integ_gain));
            mul_b = signed'(pila_pkg::MUL_B_W'(cfg.sample_period));
         end
         pila_pkg::OP_MUL_KE: begin
            mul_a = signed'(pila_pkg::MUL_A_W'(kt_ff));
            mul_b = epi_ff;
         end
         pila_pkg::OP_MUL_P: begin
            mul_a = signed'(pila_pkg::MUL_A_W'(cfg.prop_gain));
            mul_b = epi_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // saturation of the sum and back-calculated integral
   always_comb begin
      hi     = 1'b0;
      lo     = 1'b0;
      ui_new = ui_ff;
      u_sat  = u_ff;
      if (u_ff > pila_pkg::U_TOP) begin
         hi     = 1'b1;
         ui_new = pila_pkg::U_TOP - pf_ff;
         u_sat  = pila_pkg::U_TOP;
      end else if (u_ff < 0) begin
         lo     = 1'b1;
         ui_new = -pf_ff;
         u_sat  = '0;
      end
      if (ui_new > pila_pkg::INTEG_MAX) begin
         integ_sat = pila_pkg::INTEG_W'(pila_pkg::INTEG_MAX);
      end else if (ui_new < pila_pkg::INTEG_MIN) begin
         integ_sat = pila_pkg::INTEG_W'(pila_pkg::INTEG_MIN);
      end else begin
         integ_sat = pila_pkg::INTEG_W'(ui_new);
      end
      held    = (e_ff < pila_pkg::DEAD_ZONE) && (e_ff > -pila_pkg::DEAD_ZONE);
      ff_over = uff > pila_pkg::U_TOP;
   end

   // integral state
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
      end else if (cmd.op == pila_pkg::OP_CLAMP && !held) begin
         integral_ff <= integ_sat;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         pila_pkg::OP_LOAD: begin
            e_ff    <= e_in;
            epi_ff  <= epi_in;
            quot_ff <= {cfg.reference_lux[pila_pkg::LUX_W-1:pila_pkg::LUX_FRAC],
                        {pila_pkg::FF_SHIFT{1'b0}}};
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
         pila_pkg::OP_DIV_STEP: begin
            rem_ff  <= div_ge ? rem_sh - {1'b0, divisor} : rem_sh;
            quot_ff <= {quot_ff[pila_pkg::QUOT_W-2:0], div_ge};
            cnt_ff  <= cnt_ff + 1'b1;
         end
         pila_pkg::OP_MUL_KT: begin
            kt_ff <= pila_pkg::KT_W'(mul_p);
         end
         pila_pkg::OP_MUL_KE: begin
            prod_ff <= mul_p;
         end
         pila_pkg::OP_MUL_P: begin
            // floor shift of the increment happens with the product of last cycle
            ui_ff   <= pila_pkg::ACC_W'(integral_ff)
                       + pila_pkg::ACC_W'(prod_ff >>> pila_pkg::KI_SHIFT);
            prod_ff <= mul_p;
         end
         pila_pkg::OP_SUM: begin
            pf_ff <= pila_pkg::ACC_W'(prod_ff <<< pila_pkg::KP_SHIFT) + uff;
         end
         pila_pkg::OP_TOTAL: begin
            u_ff <= pf_ff + ui_ff;
         end
         pila_pkg::OP_CLAMP: begin
            res_duty_ff <= u_sat[pila_pkg::DUTY_LSB +: pila_pkg::DUTY_W];
            res_high_ff <= hi;
            res_low_ff  <= lo;
            res_held_ff <= held;
         end
         pila_pkg::OP_FF: begin
            res_duty_ff <= ff_over ? pila_pkg::DUTY_MAX
                                   : quot_ff[pila_pkg::DUTY_LSB +: pila_pkg::DUTY_W];
            res_high_ff <= ff_over;
            res_low_ff  <= 1'b0;
            res_held_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_duty_ff <= res_duty_ff;
         rsp_high_ff <= res_high_ff;
         rsp_low_ff  <= res_low_ff;
         rsp_held_ff <= res_held_ff;
      end
   end

   assign rsp_duty          = rsp_duty_ff;
   assign rsp_clamped_high  = rsp_high_ff;
   assign rsp_clamped_low   = rsp_low_ff;
   assign rsp_integral_held = rsp_held_ff;

endmodule

FILE: src/pila_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pila_controller
// Sequencer for one sample: divider run, three multiplies, sums, clamp or the
// feedforward result step, and the hand-off into the output register.
// ---------------------------------------------------------------------------
module pila_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pila_pkg::MODE_W-1:0]     mode,
   input  logic                            req_valid,
   output logic                            req_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  pila_pkg::pila_status_type       status,
   output pila_pkg::pila_cmd_type          cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_MUL_KT,
      S_MUL_KE,
      S_MUL_P,
      S_SUM,
      S_TOTAL,
      S_CLAMP,
      S_FF,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd.out_load = (state_ff == S_DONE) && out_free;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_valid ? pila_pkg::OP_LOAD : pila_pkg::OP_IDLE;
         S_DIV:    cmd.op = pila_pkg::OP_DIV_STEP;
         S_MUL_KT: cmd.op = pila_pkg::OP_MUL_KT;
         S_MUL_KE: cmd.op = pila_pkg::OP_MUL_KE;
         S_MUL_P:  cmd.op = pila_pkg::OP_MUL_P;
         S_SUM:    cmd.op = pila_pkg::OP_SUM;
         S_TOTAL:  cmd.op = pila_pkg::OP_TOTAL;
         S_CLAMP:  cmd.op = pila_pkg::OP_CLAMP;
         S_FF:     cmd.op = pila_pkg::OP_FF;
         S_DONE:   cmd.op = pila_pkg::OP_IDLE;
         default:  cmd.op = pila_pkg::OP_IDLE;
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= (mode == pila_pkg::MODE_PI) ? S_MUL_KT : S_DIV;
               end
            end
            S_DIV: begin
               if (status.div_last) begin
                  state_ff <= (mode == pila_pkg::MODE_FF) ? S_FF : S_MUL_KT;
               end
            end
            S_MUL_KT: state_ff <= S_MUL_KE;
            S_MUL_KE: state_ff <= S_MUL_P;
            S_MUL_P:  state_ff <= S_SUM;
            S_SUM:    state_ff <= S_TOTAL;
            S_TOTAL:  state_ff <= S_CLAMP;
            S_CLAMP:  state_ff <= S_DONE;
            S_FF:     state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for the lux PI controller with feedforward and anti-windup.
// Samples are driven through the request channel and the duty transactions
// are checked field by field against a cycle-free model of the control laws.
// The model keeps its own integral term and register copies. A directed set
// of samples comes first, followed by random register settings and samples
// near the set point, with random idle gaps on both channels and one long
// receiver stall.
// ---------------------------------------------------------------------------
module tb;

   // extra control law codes and register indexes that have no name upstream
   localparam logic [pila_pkg::MODE_W-1:0] MODE_DECOUPLED = 2'd2;
   localparam logic [pila_pkg::MODE_W-1:0] MODE_SPARE     = 2'd3;
   localparam logic [pila_pkg::IDX_W-1:0]  REG_SPARE_LO   = 3'd6;
   localparam logic [pila_pkg::IDX_W-1:0]  REG_SPARE_HI   = 3'd7;

   localparam longint INTEG_HI   = 64'sd2147483647;
   localparam longint INTEG_LO   = -64'sd2147483648;
   localparam int     SETTLE     = 60;    // cycles after the last duty, above latency
   localparam int     IDLE_LIMIT = 2000;  // watchdog cycles without any transaction
   localparam int     HOLD_AT    = 40;    // duty transaction index of the long stall
   localparam int     LONG_HOLD  = 300;
   localparam int     PHASES     = 8;
   localparam int     PHASE_ITEMS = 60;
   localparam int     MODE_PAD_W = pila_pkg::LUX_W - pila_pkg::MODE_W;

   typedef struct packed {
      logic [pila_pkg::DUTY_W-1:0] duty;
      logic                        clamped_high;
      logic                        clamped_low;
      logic                        integral_held;
   } duty_type;

   // control law model and store of expected duty transactions
   class duty_predictor_type;
      logic [pila_pkg::MODE_W-1:0] mode;
      logic [pila_pkg::LUX_W-1:0]  set_lux;
      logic [pila_pkg::GAIN_W-1:0] ff_gain;
      logic [pila_pkg::GAIN_W-1:0] kp;
      logic [pila_pkg::GAIN_W-1:0] ki;
      logic [pila_pkg::GAIN_W-1:0] period;
      int                          integ;
      duty_type                    duty_due[$];
      int                          errors;

      function new();
         mode    = pila_pkg::RST_MODE;
         set_lux = pila_pkg::RST_REF;
         ff_gain = pila_pkg::RST_FFG;
         kp      = pila_pkg::RST_KP;
         ki      = pila_pkg::RST_KI;
         period  = pila_pkg::RST_PERIOD;
         integ   = 0;
         errors  = 0;
      endfunction

      function void write_reg(logic [pila_pkg::IDX_W-1:0] idx,
                              logic [pila_pkg::LUX_W-1:0] data);
         case (idx)
            pila_pkg::REG_MODE:   mode    = data[pila_pkg::MODE_W-1:0];
            pila_pkg::REG_REF:    set_lux = data;
            pila_pkg::REG_FFG:    ff_gain = data;
            pila_pkg::REG_KP:     kp      = data;
            pila_pkg::REG_KI:     ki      = data;
            pila_pkg::REG_PERIOD: period  = data;
            default: ;
         endcase
      endfunction

      // whole lux over the plant gain, Q16.16; a zero gain counts as one
      function longint feedforward();
         longint whole;
         longint g;
         whole = longint'(set_lux >> pila_pkg::LUX_FRAC);
         g = (ff_gain == '0) ? 64'sd1 : longint'(ff_gain);
         return (whole <<< pila_pkg::FF_SHIFT) / g;
      endfunction

      function void note_sample(logic [pila_pkg::LUX_W-1:0] meas,
                                logic [pila_pkg::LUX_W-1:0] sim);
         longint   top;
         longint   uff;
         longint   e;
         longint   e_pi;
         longint   kt;
         longint   ui;
         longint   up;
         longint   u;
         duty_type r;
         top = longint'(pila_pkg::U_TOP);
         r = '0;
         // feedforward only: no integral update
         if (mode == pila_pkg::MODE_FF) begin
            uff = feedforward();
            if (uff > top) begin
               r.duty = pila_pkg::DUTY_MAX;
               r.clamped_high = 1'b1;
            end else begin
               r.duty = pila_pkg::DUTY_W'(uff >>> pila_pkg::DUTY_LSB);
            end
            duty_due.push_back(r);
            return;
         end
         e = longint'(set_lux) - longint'(meas);
         if (mode == pila_pkg::MODE_PI) begin
            uff  = 0;
            e_pi = e;
         end else begin
            uff  = feedforward();
            e_pi = longint'(sim) - longint'(meas);
         end
         kt = longint'(period) * longint'(ki);
         ui = longint'(integ) + ((kt * e_pi) >>> pila_pkg::KI_SHIFT);
         up = (longint'(kp) * e_pi) <<< pila_pkg::KP_SHIFT;
         u  = up + ui + uff;
         // back-calculation pins the sum on the violated bound
         if (u > top) begin
            ui = top - uff - up;
            u  = top;
            r.clamped_high = 1'b1;
         end
         if (u < 0) begin
            ui = -uff - up;
            u  = 0;
            r.clamped_low = 1'b1;
         end
         // dead zone holds the integral
         if (e >= longint'(pila_pkg::DEAD_ZONE) || e <= -longint'(pila_pkg::DEAD_ZONE)) begin
            if (ui > INTEG_HI) integ = int'(INTEG_HI);
            else if (ui < INTEG_LO) integ = int'(INTEG_LO);
            else integ = int'(ui);
         end else begin
            r.integral_held = 1'b1;
         end
         r.duty = pila_pkg::DUTY_W'(u >>> pila_pkg::DUTY_LSB);
         duty_due.push_back(r);
      endfunction

      function void check_duty(duty_type got);
         duty_type exp_r;
         if (duty_due.size() == 0) begin
            $error("unexpected duty transaction: duty %0d", got.duty);
            errors++;
            return;
         end
         exp_r = duty_due.pop_front();
         if (got.duty !== exp_r.duty) begin
            $error("duty: expected %0d, got %0d", exp_r.duty, got.duty);
            errors++;
         end
         if (got.clamped_high !== exp_r.clamped_high) begin
            $error("clamped_high: expected %0b, got %0b", exp_r.clamped_high,
                   got.clamped_high);
            errors++;
         end
         if (got.clamped_low !== exp_r.clamped_low) begin
            $error("clamped_low: expected %0b, got %0b", exp_r.clamped_low,
                   got.clamped_low);
            errors++;
         end
         if (got.integral_held !== exp_r.integral_held) begin
            $error("integral_held: expected %0b, got %0b", exp_r.integral_held,
                   got.integral_held);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [pila_pkg::IDX_W-1:0] csr_index = '0;
   logic [pila_pkg::LUX_W-1:0] csr_wdata = '0;

   pila_req_if req_bus ();
   pila_rsp_if rsp_bus ();

   duty_predictor_type predictor = new();
   int                 send_eager = 0;
   bit                 spare_toggle = 1'b0;
   int                 idle_cycles = 0;

   pi_lux_controller_antiwindup i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // known levels from time zero
   initial begin
      req_bus.valid        = 1'b0;
      req_bus.measured_lux = '0;
      req_bus.sim_lux      = '0;
      rsp_bus.ready        = 1'b0;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // gap before a sample, with runs of back-to-back samples
   function automatic int draw_send_gap();
      if (send_eager > 0) begin
         send_eager--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) send_eager = $urandom_range(10, 40);
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [pila_pkg::LUX_W-1:0] lux_near(
      logic [pila_pkg::LUX_W-1:0] center, int spread);
      int v;
      v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return pila_pkg::LUX_W'(v);
   endfunction

   // one sample transaction
   task automatic send_sample(logic [pila_pkg::LUX_W-1:0] meas,
                              logic [pila_pkg::LUX_W-1:0] sim);
      int gap;
      gap = draw_send_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.measured_lux <= meas;
      req_bus.sim_lux      <= sim;
      do @(posedge clock); while (!req_bus.ready);
      predictor.note_sample(meas, sim);
   endtask

   // stop offering and wait until every duty transaction came back
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (predictor.duty_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [pila_pkg::IDX_W-1:0] idx,
                            logic [pila_pkg::LUX_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      predictor.write_reg(idx, data);
   endtask

   // full register set, plus a write to an unused index that must be ignored
   task automatic load_settings(logic [pila_pkg::MODE_W-1:0] mode,
                                logic [pila_pkg::LUX_W-1:0]  set_lux,
                                logic [pila_pkg::GAIN_W-1:0] ffg,
                                logic [pila_pkg::GAIN_W-1:0] kp,
                                logic [pila_pkg::GAIN_W-1:0] ki,
                                logic [pila_pkg::GAIN_W-1:0] period);
      write_reg(pila_pkg::REG_MODE, {MODE_PAD_W'($urandom_range(0, 16383)), mode});
      write_reg(pila_pkg::REG_REF, set_lux);
      write_reg(pila_pkg::REG_FFG, ffg);
      write_reg(pila_pkg::REG_KP, kp);
      write_reg(pila_pkg::REG_KI, ki);
      write_reg(pila_pkg::REG_PERIOD, period);
      write_reg(spare_toggle ? REG_SPARE_HI : REG_SPARE_LO, pila_pkg::LUX_W'($urandom));
      spare_toggle = !spare_toggle;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // random register set, mostly gains that keep the loop out of the rails
   task automatic random_settings();
      logic [pila_pkg::MODE_W-1:0] mode;
      logic [pila_pkg::LUX_W-1:0]  set_lux;
      logic [pila_pkg::GAIN_W-1:0] ffg;
      logic [pila_pkg::GAIN_W-1:0] kp;
      logic [pila_pkg::GAIN_W-1:0] ki;
      logic [pila_pkg::GAIN_W-1:0] period;
      int                          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) mode = pila_pkg::MODE_FF;
      else if (pick <= 4) mode = pila_pkg::MODE_PI;
      else if (pick <= 8) mode = MODE_DECOUPLED;
      else mode = MODE_SPARE;
      if ($urandom_range(0, 1) == 0) set_lux = pila_pkg::LUX_W'($urandom);
      else set_lux = pila_pkg::LUX_W'(64 * $urandom_range(50, 900));
      case ($urandom_range(0, 9))
         0: ffg = '0;
         1: ffg = 16'd1;
         2: ffg = '1;
         default: ffg = pila_pkg::GAIN_W'($urandom_range(64, 4096));
      endcase
      kp = ($urandom_range(0, 7) == 0) ? pila_pkg::GAIN_W'($urandom)
                                       : pila_pkg::GAIN_W'($urandom_range(0, 2048));
      ki = ($urandom_range(0, 7) == 0) ? pila_pkg::GAIN_W'($urandom)
                                       : pila_pkg::GAIN_W'($urandom_range(0, 4096));
      case ($urandom_range(0, 5))
         0: period = '0;
         1: period = '1;
         2: period = pila_pkg::GAIN_W'($urandom);
         default: period = pila_pkg::GAIN_W'($urandom_range(300, 3000));
      endcase
      load_settings(mode, set_lux, ffg, kp, ki, period);
   endtask

   // random sample, mostly around the set point and the dead zone edge
   task automatic random_sample();
      logic [pila_pkg::LUX_W-1:0] meas;
      logic [pila_pkg::LUX_W-1:0] sim;
      int                         pick;
      pick = $urandom_range(0, 9);
      if (pick <= 5) meas = lux_near(predictor.set_lux, 150);
      else if (pick <= 7) meas = lux_near(predictor.set_lux, 70);
      else meas = pila_pkg::LUX_W'($urandom);
      if ($urandom_range(0, 9) < 7) sim = lux_near(meas, 200);
      else sim = pila_pkg::LUX_W'($urandom);
      send_sample(meas, sim);
   endtask

   // duty receiver with random stalls and one long hold-off
   initial begin : duty_sink
      int       wait_cycles;
      int       eager;
      int       taken;
      duty_type got;
      eager = 0;
      taken = 0;
      forever begin
         if (taken == HOLD_AT) begin
            wait_cycles = LONG_HOLD;
         end else if (eager > 0) begin
            wait_cycles = 0;
            eager--;
         end else begin
            if ($urandom_range(0, 7) == 0) eager = $urandom_range(10, 40);
            wait_cycles = $urandom_range(0, 15);
         end
         @(negedge clock);
         if (wait_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.duty          = rsp_bus.duty;
         got.clamped_high  = rsp_bus.clamped_high;
         got.clamped_low   = rsp_bus.clamped_low;
         got.integral_held = rsp_bus.integral_held;
         predictor.check_duty(got);
         taken++;
      end
   end

   // stimulus
   initial begin : stimulus
      logic [pila_pkg::LUX_W-1:0] sp;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values
      send_sample(16'd0, 16'd0);
      send_sample(16'hFFFF, 16'd0);

      // feedforward only: saturation, zero gain, unsaturated value
      drain();
      load_settings(pila_pkg::MODE_FF, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd655);
      send_sample(16'd0, 16'd0);
      send_sample(16'hFFFF, 16'hFFFF);
      drain();
      load_settings(pila_pkg::MODE_FF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd655);
      send_sample(16'd1234, 16'd4321);
      drain();
      load_settings(pila_pkg::MODE_FF, 16'd32000, 16'd1024, 16'd0, 16'd0, 16'd655);
      send_sample(16'h5555, 16'hAAAA);

      // feedback law around the dead zone edge
      drain();
      sp = 16'd32000;
      load_settings(pila_pkg::MODE_PI, sp, 16'd256, 16'd256, 16'd512, 16'd655);
      send_sample(sp, 16'd0);
      send_sample(sp - 16'd63, 16'd0);
      send_sample(sp + 16'd63, 16'd0);
      send_sample(sp - 16'd64, 16'd0);
      send_sample(sp + 16'd64, 16'd0);
      send_sample(sp - 16'd640, 16'd0);
      send_sample(sp + 16'd640, 16'd0);

      // integral saturation in both directions through back-calculation
      drain();
      load_settings(pila_pkg::MODE_PI, 16'd0, 16'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 16'd0);
      send_sample(16'd0, 16'd0);
      drain();
      load_settings(pila_pkg::MODE_PI, 16'hFFFF, 16'd256, 16'hFFFF, 16'd0, 16'd0);
      send_sample(16'd0, 16'hFFFF);
      send_sample(16'hFFFF, 16'hFFFF);

      // decoupled law and the unused mode code
      drain();
      sp = 16'd25600;
      load_settings(MODE_DECOUPLED, sp, 16'd1024, 16'd128, 16'd256, 16'd655);
      send_sample(sp, sp);
      send_sample(sp - 16'd200, sp + 16'd300);
      send_sample(16'd0, 16'hFFFF);
      drain();
      load_settings(MODE_SPARE, sp, 16'd1024, 16'd128, 16'd256, 16'd655);
      send_sample(sp - 16'd200, sp + 16'd300);
      send_sample(16'hFFFF, 16'd0);

      // all gains zero
      drain();
      load_settings(pila_pkg::MODE_PI, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      send_sample(16'd0, 16'd0);

      // random phases
      for (int p = 0; p < PHASES; p++) begin
         drain();
         random_settings();
         repeat (PHASE_ITEMS) random_sample();
      end

      drain();
      if (predictor.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
